@@ rtl/lpht_pkg.sv @@
// lpht_pkg: sizes, codes, control word layout and microcode rom of the linear probe hash table
// no dependencies; used by the channel interfaces, the table top level and the testbench
package lpht_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int KEY_BITS    = 16;
   localparam int DATA_BITS   = 32;

   localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
   localparam int KEY_IDX_W   = $clog2(KEY_BITS);
   localparam int CNT_BITS    = (SLOT_BITS > KEY_IDX_W) ? SLOT_BITS : KEY_IDX_W;
   localparam bit SLOTS_POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam int FUNC_BITS   = 2;
   localparam int STAT_BITS   = 2;

   // operation codes; code 3 behaves as a search
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_SEARCH = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_REMOVE = 2'd2
   } func_type;

   typedef enum logic [STAT_BITS-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2
   } rsp_stat_type;

   // slot state; code 3 behaves as removed
   typedef enum logic [1:0] {
      SLOT_EMPTY    = 2'd0,
      SLOT_OCCUPIED = 2'd1,
      SLOT_REMOVED  = 2'd2
   } slot_state_type;

   // datapath operation selected by one control word
   typedef enum logic [2:0] {
      OP_WAIT_REQ = 3'd0,
      OP_HOME     = 3'd1,
      OP_PROBE    = 3'd2,
      OP_COMMIT   = 3'd3,
      OP_REJECT   = 3'd4
   } op_type;

   localparam int STEP_BITS = 3;
   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_HOME   = 3'd1;
   localparam step_type STEP_PROBE  = 3'd2;
   localparam step_type STEP_COMMIT = 3'd3;
   localparam step_type STEP_REJECT = 3'd4;

   // go_step taken when the op's main condition holds, alt_step on its
   // second condition, else the step repeats
   typedef struct packed {
      op_type   op;
      step_type go_step;
      step_type alt_step;
   } ctl_word_type;

   function automatic ctl_word_type ucode_rom(step_type step);
      ctl_word_type w;
      unique case (step)
         STEP_IDLE:   w = '{op: OP_WAIT_REQ, go_step: STEP_HOME,   alt_step: STEP_IDLE};
         STEP_HOME:   w = '{op: OP_HOME,     go_step: STEP_PROBE,  alt_step: STEP_HOME};
         STEP_PROBE:  w = '{op: OP_PROBE,    go_step: STEP_COMMIT, alt_step: STEP_REJECT};
         STEP_COMMIT: w = '{op: OP_COMMIT,   go_step: STEP_IDLE,   alt_step: STEP_COMMIT};
         STEP_REJECT: w = '{op: OP_REJECT,   go_step: STEP_IDLE,   alt_step: STEP_REJECT};
         default:     w = '{op: OP_WAIT_REQ, go_step: STEP_IDLE,   alt_step: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/lpht_req_if.sv @@
// lpht_req_if: request channel carrying one table operation per beat
// depends on lpht_pkg for field widths
interface lpht_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [lpht_pkg::FUNC_BITS-1:0]       func;
   logic [lpht_pkg::KEY_BITS-1:0]        key;
   logic signed [lpht_pkg::DATA_BITS-1:0] value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);
endinterface

@@ rtl/lpht_rsp_if.sv @@
// lpht_rsp_if: response channel carrying one result per beat
// depends on lpht_pkg for field widths
interface lpht_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [lpht_pkg::STAT_BITS-1:0]        status;
   logic [lpht_pkg::SLOT_BITS-1:0]        slot_index;
   logic [lpht_pkg::KEY_BITS-1:0]         result_key;
   logic signed [lpht_pkg::DATA_BITS-1:0] result_value;

   modport source (output valid, output status, output slot_index, output result_key,
                   output result_value, input ready);
   modport sink   (input valid, input status, input slot_index, input result_key,
                   input result_value, output ready);
endinterface

@@ rtl/lpht_ram.sv @@
// lpht_ram: generic single write port, single read port ram with registered read
// no dependencies
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/linear_probe_hash_table.sv @@
// linear_probe_hash_table: open-addressing key/value table with linear probing
// depends on lpht_pkg, lpht_req_if, lpht_rsp_if and lpht_ram
//
// One request beat carries an operation (search, insert or remove), a key and, for insert,
// a value; exactly one response beat comes back per request, in order. The home slot is
// key modulo TABLE_SLOTS and the probe walks upward one slot per cycle, wrapping at the
// end. Search and remove skip removed slots and stop at a matching occupied slot, an
// empty slot or after one full wrap; insert takes the first empty or removed slot and does
// not look for duplicates. Between its accept and the next accept a request passes the
// home step, the probe loop over p slots (1 to TABLE_SLOTS) and a commit or reject step,
// which waits until the response register can take its result; the single probe loop
// reads one slot of the key/data ram per cycle. For a slot count that is not a power of
// two the home slot is reduced one key bit per cycle. Control comes from a
// five-word microcode rom indexed by a step counter. Slot states sit in flops that reset
// clears at once, so the table is usable the cycle after reset with no clearing pass. A
// finished response waits in an output register, and the next request is accepted while
// it is still pending.
module linear_probe_hash_table (
   input  logic       clock,
   input  logic       reset,
   lpht_req_if.sink   req_bus,
   lpht_rsp_if.source rsp_bus
);

   localparam int RAM_W = lpht_pkg::KEY_BITS + lpht_pkg::DATA_BITS;

   // sequencer
   lpht_pkg::step_type     step_ff, step_in;
   lpht_pkg::ctl_word_type ctl;
   logic                   go, alt;

   // request latch
   logic [lpht_pkg::FUNC_BITS-1:0]        func_ff, func_in;
   logic [lpht_pkg::KEY_BITS-1:0]         key_ff, key_in;
   logic signed [lpht_pkg::DATA_BITS-1:0] value_ff, value_in;

   // probe position and step counter
   logic [lpht_pkg::SLOT_BITS-1:0] pos_ff, pos_in;
   logic [lpht_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;

   // slot states
   lpht_pkg::slot_state_type slot_st_ff [lpht_pkg::TABLE_SLOTS];
   logic                     st_wr;
   lpht_pkg::slot_state_type st_wr_val;

   // key/data ram
   logic             ram_wr;
   logic [RAM_W-1:0] ram_rdata;
   logic [lpht_pkg::KEY_BITS-1:0]         slot_key;
   logic signed [lpht_pkg::DATA_BITS-1:0] slot_data;

   // response register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [lpht_pkg::STAT_BITS-1:0]        rsp_status_ff, rsp_status_in;
   logic [lpht_pkg::SLOT_BITS-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [lpht_pkg::KEY_BITS-1:0]         rsp_key_ff, rsp_key_in;
   logic signed [lpht_pkg::DATA_BITS-1:0] rsp_value_ff, rsp_value_in;

   // decode helpers
   logic                     is_insert, is_remove;
   lpht_pkg::slot_state_type cur_st;
   logic                     key_hit, probe_hit, probe_last;
   logic                     out_free, req_fire;
   logic                     home_done;
   logic [lpht_pkg::SLOT_BITS-1:0] home_pos, pos_next;
   logic [lpht_pkg::SLOT_BITS:0]   rem_wide;
   logic                     key_bit;

   assign ctl = lpht_pkg::ucode_rom(step_ff);

   assign req_bus.ready = (ctl.op == lpht_pkg::OP_WAIT_REQ);
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign out_free      = ~rsp_valid_ff | rsp_bus.ready;

   assign is_insert = (func_ff == lpht_pkg::FUNC_INSERT);
   assign is_remove = (func_ff == lpht_pkg::FUNC_REMOVE);

   assign slot_key  = ram_rdata[RAM_W-1 -: lpht_pkg::KEY_BITS];
   assign slot_data = ram_rdata[lpht_pkg::DATA_BITS-1:0];
   assign cur_st    = slot_st_ff[pos_ff];
   assign key_hit   = (cur_st == lpht_pkg::SLOT_OCCUPIED) && (slot_key == key_ff);
   assign probe_last = (cnt_ff == lpht_pkg::CNT_BITS'(lpht_pkg::TABLE_SLOTS - 1));

   // wrap the probe at the table end
   assign pos_next = (pos_ff == lpht_pkg::SLOT_BITS'(lpht_pkg::TABLE_SLOTS - 1)) ?
                     '0 : pos_ff + 1'b1;

   // home slot: a mask for power-of-two tables, else one restoring remainder step per key bit
   assign key_bit  = key_ff[lpht_pkg::KEY_IDX_W'(lpht_pkg::KEY_BITS - 1)
                            - cnt_ff[lpht_pkg::KEY_IDX_W-1:0]];
   assign rem_wide = {pos_ff, key_bit};

   always_comb begin
      if (lpht_pkg::SLOTS_POW2) begin
         home_pos  = lpht_pkg::SLOT_BITS'(key_ff);
         home_done = 1'b1;
      end else begin
         if (rem_wide >= (lpht_pkg::SLOT_BITS + 1)'(lpht_pkg::TABLE_SLOTS)) begin
            home_pos = lpht_pkg::SLOT_BITS'(rem_wide
                       - (lpht_pkg::SLOT_BITS + 1)'(lpht_pkg::TABLE_SLOTS));
         end else begin
            home_pos = lpht_pkg::SLOT_BITS'(rem_wide);
         end
         home_done = (cnt_ff == lpht_pkg::CNT_BITS'(lpht_pkg::KEY_BITS - 1));
      end
   end

   // insert stops at any non-occupied slot, the others at a key match
   always_comb begin
      if (is_insert) begin
         probe_hit = (cur_st != lpht_pkg::SLOT_OCCUPIED);
      end else begin
         probe_hit = key_hit;
      end
   end

   // datapath driven by the current control word
   always_comb begin
      go           = 1'b0;
      alt          = 1'b0;
      func_in      = func_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      st_wr        = 1'b0;
      st_wr_val    = lpht_pkg::SLOT_OCCUPIED;
      ram_wr       = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_value_in = rsp_value_ff;

      unique case (ctl.op)
         lpht_pkg::OP_WAIT_REQ: begin
            go = req_fire;
            if (req_fire) begin
               func_in  = req_bus.func;
               key_in   = req_bus.key;
               value_in = req_bus.value;
               pos_in   = '0;
               cnt_in   = '0;
            end
         end
         lpht_pkg::OP_HOME: begin
            go     = home_done;
            pos_in = home_pos;
            cnt_in = home_done ? '0 : cnt_ff + 1'b1;
         end
         lpht_pkg::OP_PROBE: begin
            go = probe_hit;
            // search and remove end early on an empty slot
            alt = ~probe_hit & (probe_last |
                  (~is_insert & (cur_st == lpht_pkg::SLOT_EMPTY)));
            if (~probe_hit & ~alt) begin
               pos_in = pos_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lpht_pkg::OP_COMMIT: begin
            go = out_free;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = lpht_pkg::STAT_OK;
               rsp_slot_in   = pos_ff;
               if (is_insert) begin
                  ram_wr       = 1'b1;
                  st_wr        = 1'b1;
                  st_wr_val    = lpht_pkg::SLOT_OCCUPIED;
                  rsp_key_in   = key_ff;
                  rsp_value_in = value_ff;
               end else begin
                  st_wr        = is_remove;
                  st_wr_val    = lpht_pkg::SLOT_REMOVED;
                  rsp_key_in   = slot_key;
                  rsp_value_in = slot_data;
               end
            end
         end
         lpht_pkg::OP_REJECT: begin
            go = out_free;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = is_insert ? lpht_pkg::STAT_FULL : lpht_pkg::STAT_NOT_FOUND;
               rsp_slot_in   = '0;
               rsp_key_in    = '0;
               rsp_value_in  = '0;
            end
         end
         default: begin
            go = 1'b0;
         end
      endcase
   end

   // conditional jump
   always_comb begin
      priority if (go) begin
         step_in = ctl.go_step;
      end else if (alt) begin
         step_in = ctl.alt_step;
      end else begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= lpht_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < lpht_pkg::TABLE_SLOTS; i++) begin
            slot_st_ff[i] <= lpht_pkg::SLOT_EMPTY;
         end
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (st_wr) begin
            slot_st_ff[pos_ff] <= st_wr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // read address follows the next probe position so data lines up with pos_ff
   lpht_ram #(
      .WIDTH (RAM_W),
      .DEPTH (lpht_pkg::TABLE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (pos_ff),
      .wr_data ({key_ff, value_ff}),
      .rd_addr (pos_in),
      .rd_data (ram_rdata)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.slot_index   = rsp_slot_ff;
   assign rsp_bus.result_key   = rsp_key_ff;
   assign rsp_bus.result_value = rsp_value_ff;

endmodule

@@ tb/lpht_tb_pkg.sv @@
// lpht_tb_pkg: scoreboard for the linear probe hash table testbench
// depends on lpht_pkg for sizes, operation, status and slot state codes
package lpht_tb_pkg;
   import lpht_pkg::*;

   typedef struct {
      rsp_stat_type                 status;
      logic [SLOT_BITS-1:0]         slot_index;
      logic [KEY_BITS-1:0]          key;
      logic signed [DATA_BITS-1:0]  value;
   } probe_result_type;

   class probe_table_scoreboard;
      slot_state_type              slot_state [TABLE_SLOTS];
      logic [KEY_BITS-1:0]         slot_key   [TABLE_SLOTS];
      logic signed [DATA_BITS-1:0] slot_data  [TABLE_SLOTS];
      probe_result_type            awaited_results [$];
      int errors;
      int checked;
      int status_seen [3];

      function new();
         foreach (slot_state[i]) begin
            slot_state[i] = SLOT_EMPTY;
            slot_key[i]   = '0;
            slot_data[i]  = '0;
         end
         foreach (status_seen[i]) status_seen[i] = 0;
         errors  = 0;
         checked = 0;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      // walk the probe path on the local table copy and queue the beat it should produce
      function void note_request(input logic [FUNC_BITS-1:0] func,
                                 input logic [KEY_BITS-1:0] key,
                                 input logic signed [DATA_BITS-1:0] value);
         probe_result_type r;
         int pos;
         int hit;
         r.status     = STAT_OK;
         r.slot_index = '0;
         r.key        = '0;
         r.value      = '0;
         hit = -1;
         pos = int'(key % TABLE_SLOTS);
         if (func == FUNC_INSERT) begin
            for (int n = 0; n < TABLE_SLOTS; n++) begin
               if (slot_state[pos] != SLOT_OCCUPIED) begin
                  hit = pos;
                  break;
               end
               pos = (pos + 1) % TABLE_SLOTS;
            end
         end else begin
            // search, remove and the spare code: removed slots are stepped over
            for (int n = 0; n < TABLE_SLOTS; n++) begin
               if (slot_state[pos] == SLOT_EMPTY) break;
               if (slot_state[pos] == SLOT_OCCUPIED && slot_key[pos] == key) begin
                  hit = pos;
                  break;
               end
               pos = (pos + 1) % TABLE_SLOTS;
            end
         end
         if (hit < 0) begin
            if (func == FUNC_INSERT) r.status = STAT_FULL;
            else r.status = STAT_NOT_FOUND;
         end else begin
            if (func == FUNC_INSERT) begin
               slot_state[hit] = SLOT_OCCUPIED;
               slot_key[hit]   = key;
               slot_data[hit]  = value;
            end
            r.slot_index = SLOT_BITS'(hit);
            r.key        = slot_key[hit];
            r.value      = slot_data[hit];
            if (func == FUNC_REMOVE) slot_state[hit] = SLOT_REMOVED;
         end
         awaited_results.push_back(r);
      endfunction

      function void check_response(input longint stamp,
                                   input logic [STAT_BITS-1:0] status,
                                   input logic [SLOT_BITS-1:0] slot_index,
                                   input logic [KEY_BITS-1:0] key,
                                   input logic signed [DATA_BITS-1:0] value);
         probe_result_type r;
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0d ns: unexpected response beat, expected none, actual status %0d slot %0d",
                     stamp, status, slot_index);
            return;
         end
         r = awaited_results.pop_front();
         checked++;
         status_seen[int'(r.status)]++;
         if (status !== r.status) begin
            errors++;
            $display("%0d ns: status mismatch, expected %0d actual %0d", stamp, r.status, status);
         end
         if (slot_index !== r.slot_index) begin
            errors++;
            $display("%0d ns: slot_index mismatch, expected %0d actual %0d",
                     stamp, r.slot_index, slot_index);
         end
         if (key !== r.key) begin
            errors++;
            $display("%0d ns: result_key mismatch, expected %h actual %h", stamp, r.key, key);
         end
         if (value !== r.value) begin
            errors++;
            $display("%0d ns: result_value mismatch, expected %h actual %h",
                     stamp, r.value, value);
         end
      endfunction
   endclass

endpackage

@@ tb/linear_probe_hash_table_tb.sv @@
// linear_probe_hash_table_tb: self-checking bench for the linear probe hash table
// depends on lpht_pkg, lpht_req_if, lpht_rsp_if, lpht_tb_pkg and the rtl top level
module linear_probe_hash_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lpht_pkg::*;
   import lpht_tb_pkg::*;

   // spare operation code, the block handles it as a search
   localparam logic [FUNC_BITS-1:0] FUNC_ALIAS_SEARCH = 2'd3;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_ITEMS     = 1280;
   localparam int BLOCK_ITEMS      = 60;
   localparam int QUIET_FROM       = 1100;
   localparam int HOLD_AT          = 400;
   localparam int HOLD_BEATS       = 40;
   localparam int SETTLE_AT        = 700;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 40;
   localparam int POOL_SIZE        = 24;

   logic clock;
   logic reset;

   lpht_req_if req_bus ();
   lpht_rsp_if rsp_bus ();

   linear_probe_hash_table uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   probe_table_scoreboard table_sb;
   longint cycle_count = 0;
   bit     quiet       = 1'b0;   // last part of the run: no idling on either side
   bit     hold_output = 1'b0;   // asks the receiver for one long stall
   int     gap_pct     = 20;
   logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               table_sb.pending());
      $display("status: fail");
      $finish;
   end

   // response monitor, samples the values that were present at the edge
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         table_sb.check_response($time, rsp_bus.status, rsp_bus.slot_index,
                                 rsp_bus.result_key, rsp_bus.result_value);
   end

   // receiver: bursts of back-pressure, one long hold on request, steady at the end
   initial begin
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_output) begin
            // long hold so the output register and the input side both back up
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end else if (quiet) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // offer one beat and hold it until accepted; valid stays high on return
   task automatic send_item(input logic [FUNC_BITS-1:0] func,
                            input logic [KEY_BITS-1:0] key,
                            input logic signed [DATA_BITS-1:0] value);
      req_bus.valid <= 1'b1;
      req_bus.func  <= func;
      req_bus.key   <= key;
      req_bus.value <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      table_sb.note_request(func, key, value);
   endtask

   // sender idle, with junk on the payload while valid is low
   task automatic sender_gap(input int cycles);
      req_bus.valid <= 1'b0;
      req_bus.func  <= FUNC_BITS'($urandom);
      req_bus.key   <= KEY_BITS'($urandom);
      req_bus.value <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 99) < gap_pct) sender_gap($urandom_range(1, 14));
   endtask

   // stop offering until every outstanding beat has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (table_sb.pending() != 0);
   endtask

   // directed opener: collisions on home slot 0, wrap from slot 15, removed slot
   // skipping and reuse, duplicate insert, a full table and misses on a full table
   task automatic run_directed();
      send_item(FUNC_INSERT, 16'h0000, 32'h7fffffff);
      maybe_gap();
      send_item(FUNC_INSERT, 16'h0010, 32'h80000000);
      maybe_gap();
      send_item(FUNC_INSERT, 16'hffff, 32'hffffffff);
      maybe_gap();
      // home slot 15 taken, probe wraps past slots 0 and 1
      send_item(FUNC_INSERT, 16'h000f, 32'h00000000);
      maybe_gap();
      send_item(FUNC_SEARCH, 16'h0010, 32'h12345678);
      maybe_gap();
      send_item(FUNC_SEARCH, 16'h1234, $urandom);
      maybe_gap();
      send_item(FUNC_REMOVE, 16'h0000, $urandom);
      maybe_gap();
      // search has to step over the removed slot 0
      send_item(FUNC_SEARCH, 16'h0010, $urandom);
      maybe_gap();
      send_item(FUNC_REMOVE, 16'h0000, $urandom);
      maybe_gap();
      send_item(FUNC_ALIAS_SEARCH, 16'h000f, $urandom);
      maybe_gap();
      // insert reuses the removed slot
      send_item(FUNC_INSERT, 16'h0020, 32'h00000001);
      maybe_gap();
      // duplicate key lands in a second slot
      send_item(FUNC_INSERT, 16'h0010, 32'h5a5a5a5a);
      for (int i = 0; i < 11; i++) begin
         maybe_gap();
         send_item(FUNC_INSERT, 16'h8000 | KEY_BITS'(i << 4), $urandom);
      end
      maybe_gap();
      send_item(FUNC_INSERT, 16'h7777, $urandom);
      maybe_gap();
      // misses on a full table walk the whole ring
      send_item(FUNC_SEARCH, 16'h4321, $urandom);
      maybe_gap();
      send_item(FUNC_REMOVE, 16'hfff0, $urandom);
      maybe_gap();
      send_item(FUNC_ALIAS_SEARCH, 16'hfff3, $urandom);
   endtask

   // one random operation; keys mostly from a small pool so hits and collisions are common
   task automatic random_item(input bit fill_bias);
      int r;
      logic [FUNC_BITS-1:0] f;
      logic [KEY_BITS-1:0]  k;
      r = $urandom_range(0, 99);
      if (fill_bias) begin
         if (r < 55)      f = FUNC_INSERT;
         else if (r < 80) f = FUNC_SEARCH;
         else if (r < 98) f = FUNC_REMOVE;
         else             f = FUNC_ALIAS_SEARCH;
      end else begin
         if (r < 20)      f = FUNC_INSERT;
         else if (r < 45) f = FUNC_SEARCH;
         else if (r < 98) f = FUNC_REMOVE;
         else             f = FUNC_ALIAS_SEARCH;
      end
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else k = KEY_BITS'($urandom);
      send_item(f, k, $urandom);
   endtask

   initial begin
      bit fill_bias;
      table_sb = new();
      reset = 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func  <= FUNC_SEARCH;
      req_bus.key   <= '0;
      req_bus.value <= '0;

      // pool starts with the keys the directed part leaves in the table
      key_pool[0] = 16'h0010;
      key_pool[1] = 16'hffff;
      key_pool[2] = 16'h000f;
      key_pool[3] = 16'h0020;
      for (int i = 0; i < 11; i++) key_pool[4 + i] = 16'h8000 | KEY_BITS'(i << 4);
      for (int i = 15; i < POOL_SIZE; i++) key_pool[i] = KEY_BITS'($urandom);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      // sender pause until the table has answered everything
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % BLOCK_ITEMS == 0) begin
            // alternate draining and filling so the table cycles between sparse and full
            fill_bias = ((i / BLOCK_ITEMS) % 2) == 1;
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            repeat (4) key_pool[$urandom_range(0, POOL_SIZE - 1)] = KEY_BITS'($urandom);
         end
         if (i == QUIET_FROM) quiet = 1'b1;
         if (i == HOLD_AT) hold_output = 1'b1;
         if (i == SETTLE_AT) wait_drained();
         // keep offering back to back while the receiver holds off
         if (i < HOLD_AT || i >= HOLD_AT + HOLD_BEATS) maybe_gap();
         random_item(fill_bias);
      end

      req_bus.valid <= 1'b0;
      while (table_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d operations: %0d hits or writes, %0d misses, %0d inserts on a full table",
               table_sb.checked, table_sb.status_seen[0], table_sb.status_seen[1],
               table_sb.status_seen[2]);
      $display("with a %0d-cycle output stall, two full drains and random idling on both sides",
               LONG_HOLD_CYCLES);
      if (table_sb.errors == 0 && table_sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/lpht_pkg.sv
rtl/lpht_req_if.sv
rtl/lpht_rsp_if.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table.sv
tb/lpht_tb_pkg.sv
tb/linear_probe_hash_table_tb.sv
